// ===== design/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
// Holds the beat structs, the action codes and the controller states.
// No dependencies.
`default_nettype none

package bba_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned ChunkBits = 8;
  localparam int unsigned RunW      = 16;
  localparam int unsigned CfgAddrW  = 3;

  localparam logic [31:0] FullWord      = 32'hFFFF_FFFF;
  localparam logic [14:0] BlockCountRst = 15'd16384;
  // Register index as carried by paddr bit 2.
  localparam logic        RegBlockCount = 1'b0;

  typedef enum logic [2:0] {
    ACT_ALLOC     = 3'd0,
    ACT_FREE      = 3'd1,
    ACT_MARK_USED = 3'd2,
    ACT_MARK_FREE = 3'd3,
    ACT_TEST      = 3'd4
  } act_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_TEST_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_BITS,
    ST_RNG_RD,
    ST_RNG_MOD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [13:0] block_index;
    logic [14:0] run_length;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [13:0] found_index;
    logic        block_in_use;
    logic [14:0] blocks_used;
  } rsp_t;

  typedef struct packed {
    logic            found;
    logic            new_start;
    logic [2:0]      start_pos;
    logic [RunW-1:0] run;
  } chunk_res_t;

endpackage

`default_nettype wire

// ===== design/bba_chunk_scan.sv =====
// First-fit run tracking over one eight-bit slice of a bitmap word.
// Depends on bba_pkg.
`default_nettype none

module bba_chunk_scan (
  input  wire logic [bba_pkg::ChunkBits-1:0] chunk_i,
  input  wire logic [bba_pkg::RunW-1:0]      run_i,
  input  wire logic [14:0]                   len_i,
  output bba_pkg::chunk_res_t                res_o
);

  always_comb begin
    logic [bba_pkg::RunW-1:0] run;
    logic                     found;
    logic                     new_start;
    logic [2:0]               pos;
    run       = run_i;
    found     = 1'b0;
    new_start = 1'b0;
    pos       = '0;
    for (int k = 0; k < bba_pkg::ChunkBits; k++) begin
      if (!found) begin
        if (chunk_i[k]) begin
          run = '0;
        end else begin
          if (run == '0) begin
            new_start = 1'b1;
            pos       = 3'(k);
          end
          run = run + 1'b1;
          if (run == {1'b0, len_i}) begin
            found = 1'b1;
          end
        end
      end
    end
    res_o.found     = found;
    res_o.new_start = new_start;
    res_o.start_pos = pos;
    res_o.run       = run;
  end

endmodule

`default_nettype wire

// ===== design/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator: bitmap memory, controller,
// configuration port and result register. Depends on bba_pkg and bba_chunk_scan.
//
//  channel | direction | handshake              | beat
//  in      | input     | in_valid_i / in_stall_o   | bba_pkg::req_t
//  out     | output    | out_valid_o / out_stall_i | bba_pkg::rsp_t
//  config  | input     | psel/penable/pwrite/pready| block_count at byte 0
//
// One item is in work at a time. A test reads one bitmap word; free and mark
// read and rewrite each bitmap word touched. Allocate reads one word at a time,
// scanning a word holding both used and free blocks one eight-bit chunk at a
// time, then marks the run by a read and a write of each word. After reset a
// clearing pass writes every word to all-used, during which no item is taken.
// A stalled output holds the finished beat while the next item may already be
// accepted.
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned BLOCK_TOTAL = 16384
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bba_pkg::req_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bba_pkg::rsp_t                      out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bba_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned Words = (BLOCK_TOTAL + bba_pkg::WordBits - 1) / bba_pkg::WordBits;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CW    = $clog2(BLOCK_TOTAL + 1);
  localparam int unsigned PW    = (CW > 16) ? CW : 16;
  localparam int unsigned WW    = PW - 5;
  localparam int unsigned RunBits = bba_pkg::RunW;

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      s = s + 6'(v[i]);
    end
    return s;
  endfunction

  // Bitmap memory, one word per 32 blocks, registered read.
  logic [31:0]   mem_q [Words];
  logic [31:0]   rd_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Configuration.
  logic [14:0] block_count_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bba_pkg::RegBlockCount);
  assign prdata = (paddr[2] == bba_pkg::RegBlockCount) ? {17'b0, block_count_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= bba_pkg::BlockCountRst;
    end else if (cfg_wr) begin
      block_count_q <= pwdata[14:0];
    end
  end

  // Controller state.
  bba_pkg::state_e state_q, state_d;
  logic [AW-1:0]   init_q, init_d;
  logic [2:0]      act_q, act_d;
  logic [14:0]     len_q, len_d;
  logic [13:0]     idx_q, idx_d;
  logic [WW-1:0]   wp_q, wp_d, last_q, last_d;
  logic [PW-1:0]   s_q, s_d, e_q, e_d, first_q, first_d;
  logic [bba_pkg::RunW-1:0] run_q, run_d;
  logic [1:0]      chunk_q, chunk_d;
  logic [CW-1:0]   used_q, used_d;
  logic            succ_q, succ_d, inuse_q, inuse_d;
  logic [13:0]     found_q, found_d;
  logic            out_valid_q, out_valid_d;
  bba_pkg::rsp_t   out_q, out_d;

  bba_pkg::chunk_res_t chunk_res;
  logic [7:0]          chunk_bits;

  assign chunk_bits = rd_q[chunk_q*8 +: 8];

  bba_chunk_scan u_chunk_scan (
    .chunk_i (chunk_bits),
    .run_i   (run_q),
    .len_i   (len_q),
    .res_o   (chunk_res)
  );

  logic          in_acc;
  logic [PW-1:0] num_p, eff, in_s, in_end_raw, in_e;
  logic [WW-1:0] scan_words;

  assign in_stall_o  = (state_q != bba_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign num_p       = PW'(BLOCK_TOTAL);
  assign eff         = (PW'(block_count_q) < num_p) ? PW'(block_count_q) : num_p;
  assign scan_words  = WW'(eff >> 5);
  assign in_s        = PW'(in_data_i.block_index);
  assign in_end_raw  = in_s + PW'(in_data_i.run_length);
  assign in_e        = (in_end_raw > num_p) ? num_p : in_end_raw;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic          hit;
    logic [PW-1:0] hit_start;
    logic [PW-1:0] hit_end;
    logic [PW:0]   sum_w;
    logic [PW-1:0] el;
    logic [4:0]    lo, hi;
    logic [31:0]   mask;
    logic [5:0]    pc;
    logic [CW:0]   used_sum;
    state_d     = state_q;
    init_d      = init_q;
    act_d       = act_q;
    len_d       = len_q;
    idx_d       = idx_q;
    wp_d        = wp_q;
    last_d      = last_q;
    s_d         = s_q;
    e_d         = e_q;
    first_d     = first_q;
    run_d       = run_q;
    chunk_d     = chunk_q;
    used_d      = used_q;
    succ_d      = succ_q;
    inuse_d     = inuse_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = AW'(wp_q);
    wr_en       = 1'b0;
    wr_addr     = AW'(wp_q);
    wr_data     = rd_q;
    hit         = 1'b0;
    hit_start   = first_q;
    hit_end     = '0;
    sum_w       = '0;
    el          = e_q - 1'b1;
    lo          = (wp_q == s_q[PW-1:5]) ? s_q[4:0] : 5'd0;
    hi          = (wp_q == last_q) ? el[4:0] : 5'd31;
    mask        = (bba_pkg::FullWord << lo) & (bba_pkg::FullWord >> (5'd31 - hi));
    pc          = '0;
    used_sum    = '0;

    case (state_q)
      bba_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_q;
        wr_data = bba_pkg::FullWord;
        if (init_q == AW'(Words - 1)) begin
          state_d = bba_pkg::ST_IDLE;
        end else begin
          init_d = init_q + 1'b1;
        end
      end

      bba_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_d   = in_data_i.action;
          len_d   = in_data_i.run_length;
          idx_d   = in_data_i.block_index;
          succ_d  = 1'b1;
          inuse_d = 1'b0;
          found_d = '0;
          s_d     = in_s;
          e_d     = in_e;
          wp_d    = WW'(in_s >> 5);
          last_d  = WW'((in_e - 1'b1) >> 5);
          state_d = bba_pkg::ST_DONE;
          case (bba_pkg::act_e'(in_data_i.action))
            bba_pkg::ACT_ALLOC: begin
              if (in_data_i.run_length == '0 || PW'(used_q) >= eff) begin
                succ_d = 1'b0;
              end else begin
                wp_d    = '0;
                run_d   = '0;
                state_d = bba_pkg::ST_SCAN_RD;
              end
            end
            bba_pkg::ACT_FREE: begin
              if (in_s >= in_e) begin
                used_d = (CW'(in_data_i.run_length) >= used_q ||
                          CW > 15 && in_data_i.run_length > 15'(used_q)) ?
                         '0 : used_q - CW'(in_data_i.run_length);
                if ((CW + 1)'(in_data_i.run_length) >= (CW + 1)'(used_q)) begin
                  used_d = '0;
                end
              end else begin
                state_d = bba_pkg::ST_RNG_RD;
              end
            end
            bba_pkg::ACT_MARK_USED, bba_pkg::ACT_MARK_FREE: begin
              if (in_s < in_e) begin
                state_d = bba_pkg::ST_RNG_RD;
              end
            end
            bba_pkg::ACT_TEST: begin
              if (in_s < num_p) begin
                rd_en   = 1'b1;
                rd_addr = AW'(in_s >> 5);
                state_d = bba_pkg::ST_TEST_CHK;
              end
            end
            default: begin
              state_d = bba_pkg::ST_DONE;
            end
          endcase
        end
      end

      bba_pkg::ST_TEST_CHK: begin
        inuse_d = rd_q[idx_q[4:0]];
        state_d = bba_pkg::ST_DONE;
      end

      bba_pkg::ST_SCAN_RD: begin
        if (wp_q == scan_words) begin
          succ_d  = 1'b0;
          state_d = bba_pkg::ST_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = bba_pkg::ST_SCAN_CHK;
        end
      end

      bba_pkg::ST_SCAN_CHK: begin
        if (rd_q == bba_pkg::FullWord) begin
          run_d   = '0;
          wp_d    = wp_q + 1'b1;
          state_d = bba_pkg::ST_SCAN_RD;
        end else if (rd_q == '0) begin
          // A wholly free word extends the current run by 32 blocks.
          if (run_q == '0) begin
            first_d = {wp_q, 5'd0};
          end
          if ((RunBits + 1)'(run_q) + (RunBits + 1)'(32) >= (RunBits + 1)'(len_q)) begin
            hit       = 1'b1;
            hit_start = (run_q == '0) ? {wp_q, 5'd0} : first_q;
          end else begin
            run_d   = run_q + RunBits'(32);
            wp_d    = wp_q + 1'b1;
            state_d = bba_pkg::ST_SCAN_RD;
          end
        end else begin
          chunk_d = '0;
          state_d = bba_pkg::ST_SCAN_BITS;
        end
      end

      bba_pkg::ST_SCAN_BITS: begin
        run_d = chunk_res.run;
        if (chunk_res.new_start) begin
          first_d = {wp_q, chunk_q, chunk_res.start_pos};
        end
        if (chunk_res.found) begin
          hit       = 1'b1;
          hit_start = chunk_res.new_start ? {wp_q, chunk_q, chunk_res.start_pos} : first_q;
        end else if (chunk_q == 2'd3) begin
          wp_d    = wp_q + 1'b1;
          state_d = bba_pkg::ST_SCAN_RD;
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end

      bba_pkg::ST_RNG_RD: begin
        rd_en   = 1'b1;
        state_d = bba_pkg::ST_RNG_MOD;
      end

      bba_pkg::ST_RNG_MOD: begin
        wr_en = 1'b1;
        case (bba_pkg::act_e'(act_q))
          bba_pkg::ACT_ALLOC: begin
            wr_data = rd_q | mask;
          end
          bba_pkg::ACT_MARK_USED: begin
            wr_data  = rd_q | mask;
            pc       = pop32(mask & ~rd_q);
            used_sum = (CW + 1)'(used_q) + (CW + 1)'(pc);
            used_d   = (used_sum >= (CW + 1)'(BLOCK_TOTAL)) ? CW'(BLOCK_TOTAL) : CW'(used_sum);
          end
          bba_pkg::ACT_MARK_FREE: begin
            wr_data = rd_q & ~mask;
            pc      = pop32(mask & rd_q);
            used_d  = ((CW + 6)'(pc) >= (CW + 6)'(used_q)) ? '0 : used_q - CW'(pc);
          end
          default: begin
            wr_data = rd_q & ~mask;
          end
        endcase
        if (wp_q == last_q) begin
          if (act_q == bba_pkg::ACT_FREE) begin
            used_d = ((CW + 16)'(len_q) >= (CW + 16)'(used_q)) ? '0 : used_q - CW'(len_q);
          end
          state_d = bba_pkg::ST_DONE;
        end else begin
          wp_d    = wp_q + 1'b1;
          state_d = bba_pkg::ST_RNG_RD;
        end
      end

      bba_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.success     = succ_q;
          out_d.found_index = found_q;
          out_d.block_in_use = inuse_q;
          out_d.blocks_used = 15'(used_q);
          state_d           = bba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bba_pkg::ST_IDLE;
      end
    endcase

    // A run was found: mark it from its first block and book the count now.
    if (hit) begin
      hit_end = hit_start + PW'(len_q);
      sum_w   = (PW + 1)'(used_q) + (PW + 1)'(len_q);
      used_d  = (sum_w >= (PW + 1)'(BLOCK_TOTAL)) ? CW'(BLOCK_TOTAL) : CW'(sum_w);
      found_d = 14'(hit_start);
      s_d     = hit_start;
      e_d     = hit_end;
      wp_d    = WW'(hit_start >> 5);
      last_d  = WW'((hit_end - 1'b1) >> 5);
      state_d = bba_pkg::ST_RNG_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::ST_INIT;
      init_q      <= '0;
      used_q      <= CW'(BLOCK_TOTAL);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    len_q   <= len_d;
    idx_q   <= idx_d;
    wp_q    <= wp_d;
    last_q  <= last_d;
    s_q     <= s_d;
    e_q     <= e_d;
    first_q <= first_d;
    run_q   <= run_d;
    chunk_q <= chunk_d;
    succ_q  <= succ_d;
    inuse_q <= inuse_d;
    found_q <= found_d;
    out_q   <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW + 1)'(used_q) <= (PW + 1)'(BLOCK_TOTAL))
    else $error("used count beyond the number of blocks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == bba_pkg::ST_INIT || state_q == bba_pkg::ST_RNG_MOD))
    else $error("bitmap written outside the clearing pass or a range update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_INIT) |-> in_stall_o)
    else $error("item taken during the clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_RNG_MOD) |-> $past(rd_en))
    else $error("range update without a bitmap read");

endmodule

`default_nettype wire

// ===== test/tb_bitmap_block_allocator.sv =====
// Testbench for the first-fit bitmap block allocator: random and directed
// allocate, free, mark and test beats checked against a bitmap predictor.
// Depends on bba_pkg and bitmap_block_allocator.
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;

  localparam int unsigned NumBlocks = 16384;
  localparam int unsigned MapWords  = NumBlocks / 32;
  localparam logic [2:0]  ActUndefLo = 3'd5;
  localparam logic [2:0]  ActUndefHi = 3'd7;
  localparam logic [2:0]  RegSpare    = 3'd4;
  localparam logic [2:0]  RegCountAdr = 3'd0;

  class alloc_board;
    logic [31:0] usage [MapWords];
    int unsigned used;
    int unsigned limit;
    bba_pkg::rsp_t due [$];

    function new();
      foreach (usage[w]) usage[w] = bba_pkg::FullWord;
      used  = NumBlocks;
      limit = 16384;
    endfunction

    function void set_limit(logic [31:0] v);
      limit = v & 32'h7FFF;
    endfunction

    function void grow(int unsigned n);
      if (used >= NumBlocks || n >= NumBlocks - used) used = NumBlocks;
      else used += n;
    endfunction

    function void shrink(int unsigned n);
      used = (n >= used) ? 0 : used - n;
    endfunction

    function bit first_fit(int unsigned len, output int unsigned start);
      int unsigned eff, run, first;
      eff = (limit < NumBlocks) ? limit : NumBlocks;
      run = 0;
      first = 0;
      start = 0;
      for (int unsigned w = 0; w < eff / 32; w++) begin
        if (usage[w] == bba_pkg::FullWord) begin
          run = 0;
          continue;
        end
        for (int unsigned j = 0; j < 32; j++) begin
          if (usage[w][j]) begin
            run = 0;
            continue;
          end
          if (run == 0) first = w * 32 + j;
          run++;
          if (run == len) begin
            start = first;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note(bba_pkg::req_t r);
      bba_pkg::rsp_t e;
      int unsigned   len, start, b, eff;
      len = r.run_length;
      eff = (limit < NumBlocks) ? limit : NumBlocks;
      e = '0;
      e.success = 1'b1;
      case (r.action)
        bba_pkg::ACT_ALLOC: begin
          if (len == 0 || used >= eff || !first_fit(len, start)) begin
            e.success = 1'b0;
          end else begin
            for (int unsigned i = 0; i < len; i++) usage[(start + i) / 32][(start + i) % 32] = 1'b1;
            grow(len);
            e.found_index = 14'(start);
          end
        end
        bba_pkg::ACT_FREE: begin
          for (int unsigned i = 0; i < len; i++) begin
            b = r.block_index + i;
            if (b >= NumBlocks) break;
            usage[b / 32][b % 32] = 1'b0;
          end
          shrink(len);
        end
        bba_pkg::ACT_MARK_USED, bba_pkg::ACT_MARK_FREE: begin
          for (int unsigned i = 0; i < len; i++) begin
            b = r.block_index + i;
            if (b >= NumBlocks) break;
            if (r.action == bba_pkg::ACT_MARK_USED && !usage[b / 32][b % 32]) begin
              usage[b / 32][b % 32] = 1'b1;
              grow(1);
            end else if (r.action == bba_pkg::ACT_MARK_FREE && usage[b / 32][b % 32]) begin
              usage[b / 32][b % 32] = 1'b0;
              shrink(1);
            end
          end
        end
        bba_pkg::ACT_TEST: e.block_in_use = usage[r.block_index / 32][r.block_index % 32];
        default: ;
      endcase
      e.blocks_used = used[14:0];
      due.push_back(e);
    endfunction

    // Returns an empty string when the beat matches the oldest expectation.
    function string check(bba_pkg::rsp_t got);
      bba_pkg::rsp_t e;
      if (due.size() == 0) return $sformatf("unexpected result beat %p", got);
      e = due.pop_front();
      if (got.success !== e.success)
        return $sformatf("success %b, expected %b", got.success, e.success);
      if (got.found_index !== e.found_index)
        return $sformatf("found_index %0d, expected %0d", got.found_index, e.found_index);
      if (got.block_in_use !== e.block_in_use)
        return $sformatf("block_in_use %b, expected %b", got.block_in_use, e.block_in_use);
      if (got.blocks_used !== e.blocks_used)
        return $sformatf("blocks_used %0d, expected %0d", got.blocks_used, e.blocks_used);
      return "";
    endfunction
  endclass

  logic          clk_i, rst_ni;
  logic          in_valid, in_stall, out_valid, out_stall;
  bba_pkg::req_t in_data;
  bba_pkg::rsp_t out_data;
  logic          psel, penable, pwrite, pready;
  logic [2:0]    paddr;
  logic [31:0]   pwdata, prdata;

  alloc_board  board;
  int unsigned errors;
  int unsigned burst_left;
  bit          hold_req, no_gaps;

  bitmap_block_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Result side: checked at the rising edge at which the beat is taken.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid && !out_stall) begin
      msg = board.check(out_data);
      if (msg != "") report(msg);
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  initial begin
    int unsigned mode;
    out_stall = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  task automatic apb_access(logic [2:0] adr, logic wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= adr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_block_count(logic [14:0] bc);
    logic [31:0] rd;
    apb_access(RegCountAdr, 1'b1, {$urandom} & 32'hFFFF_8000 | bc, rd);
    board.set_limit(bc);
    apb_access(RegCountAdr, 1'b0, '0, rd);
    if (rd[14:0] !== bc) report($sformatf("block_count read %0d, expected %0d", rd, bc));
  endtask

  task automatic send(bba_pkg::act_e act, int unsigned idx, int unsigned len);
    bba_pkg::req_t r;
    int unsigned   gap;
    r.action = act;
    r.block_index = idx[13:0];
    r.run_length = len[14:0];
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk_i); while (in_stall);
    board.note(r);
    if (no_gaps) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Waits for every expected result, then for the block to settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_item(int unsigned span);
    int unsigned   pick, idx, len;
    bba_pkg::act_e act;
    pick = $urandom_range(0, 99);
    if (pick < 35) act = bba_pkg::ACT_ALLOC;
    else if (pick < 52) act = bba_pkg::ACT_FREE;
    else if (pick < 62) act = bba_pkg::ACT_MARK_USED;
    else if (pick < 78) act = bba_pkg::ACT_MARK_FREE;
    else if (pick < 98) act = bba_pkg::ACT_TEST;
    else act = bba_pkg::act_e'(3'($urandom_range(ActUndefLo, ActUndefHi)));
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, span);
    pick = $urandom_range(0, 99);
    if (pick < 85) len = $urandom_range(1, 24);
    else if (pick < 96) len = $urandom_range(0, 200);
    else len = $urandom_range(0, 32767);
    send(act, idx, len);
  endtask

  initial begin
    logic [14:0] settings [9];
    int unsigned counts [9];
    int unsigned span;
    board = new();
    errors = 0;
    burst_left = 0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset block count.
    send(bba_pkg::ACT_TEST, 0, 0);
    send(bba_pkg::ACT_ALLOC, 0, 0);
    send(bba_pkg::ACT_ALLOC, 0, 5);
    send(bba_pkg::ACT_FREE, 0, 64);
    send(bba_pkg::ACT_TEST, 3, 1);
    send(bba_pkg::ACT_ALLOC, 0, 1);
    send(bba_pkg::ACT_ALLOC, 0, 63);
    send(bba_pkg::ACT_ALLOC, 0, 2);
    send(bba_pkg::ACT_MARK_FREE, 10, 11);
    send(bba_pkg::ACT_MARK_USED, 5, 10);
    send(bba_pkg::ACT_MARK_FREE, 16380, 100);
    send(bba_pkg::ACT_TEST, 16383, 0);
    send(bba_pkg::ACT_MARK_USED, 16380, 32767);
    send(bba_pkg::ACT_FREE, 16383, 1);
    send(bba_pkg::act_e'(ActUndefLo), 16383, 32767);
    send(bba_pkg::act_e'(3'd6), 1, 1);
    send(bba_pkg::act_e'(ActUndefHi), 0, 0);
    send(bba_pkg::ACT_FREE, 0, 32767);
    send(bba_pkg::ACT_ALLOC, 0, 16384);
    send(bba_pkg::ACT_TEST, 16383, 0);
    send(bba_pkg::ACT_MARK_FREE, 0, 16384);
    send(bba_pkg::ACT_ALLOC, 0, 16385);
    send(bba_pkg::ACT_ALLOC, 0, 32767);
    send(bba_pkg::ACT_TEST, 16382, 0);
    drain();

    // The spare register address must not disturb block_count.
    begin
      logic [31:0] rd;
      apb_access(RegSpare, 1'b1, 32'd7, rd);
      apb_access(RegCountAdr, 1'b0, '0, rd);
      if (rd[14:0] !== 15'(board.limit)) report("block_count changed by spare write");
    end

    settings = '{15'd16384, 15'd1000, 15'd0, 15'd31, 15'd32, 15'd100,
                 15'd4000, 15'd32767, 15'($urandom_range(0, 32767))};
    counts = '{100, 250, 60, 60, 120, 150, 200, 100, 110};
    foreach (settings[p]) begin
      set_block_count(settings[p]);
      span = (settings[p] + 31 < 16383) ? settings[p] + 31 : 16383;
      if (p == 1) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
      end
      for (int unsigned k = 0; k < counts[p]; k++) begin
        if (p == 1 && k == 40) no_gaps = 1'b0;
        random_item(span);
      end
      drain();
    end

    if (board.due.size() != 0) report("results still expected at the end");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // pready is driven by the block; nothing to do here beyond the port.
endmodule
